// File: sv/ilsp_pkg.sv
// Package for the inductive line steering block: widths, register codes, shared types.
// No dependencies.
`default_nettype none
package ilsp_pkg;
  localparam int Rounds     = 5;
  localparam int SampleBits = 12;
  localparam int DerivLag   = 3;
  localparam int RndW       = $clog2(Rounds);
  localparam int DerivLimit = 22938;

  typedef enum logic [2:0] {
    REG_P_GAIN      = 3'd0,
    REG_D_GAIN      = 3'd1,
    REG_RP_GAIN     = 3'd2,
    REG_RD_GAIN     = 3'd3,
    REG_STOP_THR    = 3'd4,
    REG_ENTER_HIGH  = 3'd5,
    REG_ENTER_LOW   = 3'd6,
    REG_EXIT_LEVEL  = 3'd7
  } reg_idx_e;

  typedef logic [SampleBits-1:0] samp_t;

  // One queued round set: the trimmed, quantised channel values.
  typedef struct packed {
    samp_t h_l;
    samp_t h_r;
    samp_t v_l;
    samp_t v_r;
  } chan_vals_t;

  typedef struct packed {
    logic [12:0] p_gain;
    logic [12:0] d_gain;
    logic [12:0] rp_gain;
    logic [12:0] rd_gain;
    logic [11:0] stop_thr;
    logic [11:0] enter_high;
    logic [11:0] enter_low;
    logic [11:0] exit_level;
  } cfg_t;
endpackage
`default_nettype wire

// File: sv/inductive_line_steering_pd.sv
// Inductive line steering PD controller, top level.
// One result per five input rounds.
// Front reduction scans each channel in turn; the back end runs two serial divides, one per channel pair.
// The two-entry queue lets the front collect new rounds while the back end works.
// Reset is asynchronous, active low, and restores register defaults and clears all flags.
`default_nettype none
module inductive_line_steering_pd import ilsp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] horiz_left_i,
  input  wire logic [11:0] horiz_right_i,
  input  wire logic [11:0] vert_left_i,
  input  wire logic [11:0] vert_right_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [14:0] drive_o,
  output logic             stop_latched_o,
  output logic             in_roundabout_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  cfg_t cfg_q;
  logic f_valid, f_ready, b_valid, b_ready;
  chan_vals_t f_data, b_data;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{p_gain: 13'd700, d_gain: 13'd2200, rp_gain: 13'd700, rd_gain: 13'd1600,
                 stop_thr: 12'd50, enter_high: 12'd2300, enter_low: 12'd800,
                 exit_level: 12'd200};
    end else if (cfg_valid) begin
      case (reg_idx_e'(cfg_index))
        REG_P_GAIN:     cfg_q.p_gain <= cfg_data;
        REG_D_GAIN:     cfg_q.d_gain <= cfg_data;
        REG_RP_GAIN:    cfg_q.rp_gain <= cfg_data;
        REG_RD_GAIN:    cfg_q.rd_gain <= cfg_data;
        REG_STOP_THR:   cfg_q.stop_thr <= cfg_data[11:0];
        REG_ENTER_HIGH: cfg_q.enter_high <= cfg_data[11:0];
        REG_ENTER_LOW:  cfg_q.enter_low <= cfg_data[11:0];
        REG_EXIT_LEVEL: cfg_q.exit_level <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  ilsp_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_valid), .in_ready(in_ready),
    .horiz_left_i(horiz_left_i), .horiz_right_i(horiz_right_i),
    .vert_left_i(vert_left_i), .vert_right_i(vert_right_i),
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_data_o(f_data)
  );

  ilsp_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .w_valid_i(f_valid), .w_ready_o(f_ready),
    .w_data_i(f_data), .r_valid_o(b_valid), .r_ready_i(b_ready), .r_data_o(b_data)
  );

  ilsp_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q), .q_valid_i(b_valid),
    .q_ready_o(b_ready), .q_data_i(b_data), .out_valid(out_valid),
    .out_ready(out_ready), .drive_o(drive_o), .stop_latched_o(stop_latched_o),
    .in_roundabout_o(in_roundabout_o)
  );

`ifndef SYNTH
  // The stop flag is sticky once set.
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_latched_o |=> stop_latched_o) else $error("stop flag cleared");
  // A waiting result keeps its drive value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(drive_o)) else $error("drive changed while stalled");
  // A full queue always has an entry to read.
  a_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !f_ready |-> b_valid) else $error("queue full but empty");
`endif
endmodule
`default_nettype wire

// File: sv/ilsp_front.sv
// Front end: stores sample rounds and reduces each channel to a trimmed mean.
// Depends on ilsp_pkg.
`default_nettype none
module ilsp_front import ilsp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire samp_t      horiz_left_i,
  input  wire samp_t      horiz_right_i,
  input  wire samp_t      vert_left_i,
  input  wire samp_t      vert_right_i,
  output logic            q_valid_o,
  input  wire logic       q_ready_i,
  output chan_vals_t      q_data_o
);
  typedef enum logic [1:0] {S_COLLECT, S_REDUCE, S_PUSH} st_e;

  localparam int SumW     = SampleBits + 3;
  localparam int ChW      = 2;
  // Dividing by the inner count and by ten is one reciprocal product.
  localparam int MeanDiv  = (Rounds - 2) * 10;
  localparam int RecipSh  = 20;
  localparam int Recip    = ((1 << RecipSh) + MeanDiv - 1) / MeanDiv;

  st_e st_q;
  logic [RndW-1:0] slot_q;
  logic [ChW-1:0] ch_q;
  logic [RndW:0]  k_q;
  samp_t store_q [4][Rounds];
  samp_t vals_q [4];
  samp_t mn_q, mx_q;
  logic [SumW-1:0] sum_q;
  samp_t cur;
  logic [SumW-1:0] tot;
  logic [31:0] scaled;
  samp_t q10;

  assign in_ready  = (st_q == S_COLLECT);
  assign q_valid_o = (st_q == S_PUSH);
  assign q_data_o  = '{h_l: vals_q[0], h_r: vals_q[1], v_l: vals_q[2], v_r: vals_q[3]};
  assign cur = store_q[ch_q][k_q[RndW-1:0]];

  // Trimmed mean: total minus min and max, scaled by the reciprocal, cut to tens.
  always_comb begin
    tot    = sum_q - SumW'(mn_q) - SumW'(mx_q);
    scaled = 32'(tot) * 32'(Recip);
    q10    = SampleBits'(scaled >> RecipSh) * SampleBits'(10);
  end

  // Sample storage.
  always_ff @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      store_q[0][slot_q] <= horiz_left_i;
      store_q[1][slot_q] <= horiz_right_i;
      store_q[2][slot_q] <= vert_left_i;
      store_q[3][slot_q] <= vert_right_i;
    end
  end

  // Sequencer: collect rounds, then scan one sample a cycle per channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_COLLECT;
      slot_q <= '0;
      ch_q <= '0;
      k_q <= '0;
      sum_q <= '0;
      mn_q <= '0;
      mx_q <= '0;
    end else begin
      case (st_q)
        S_COLLECT: begin
          if (in_valid) begin
            if (slot_q == RndW'(Rounds - 1)) begin
              slot_q <= '0;
              st_q <= S_REDUCE;
              ch_q <= '0;
              k_q <= '0;
              sum_q <= '0;
              mn_q <= '1;
              mx_q <= '0;
            end else begin
              slot_q <= slot_q + 1'b1;
            end
          end
        end
        S_REDUCE: begin
          if (k_q == (RndW+1)'(Rounds)) begin
            vals_q[ch_q] <= q10;
            k_q <= '0;
            sum_q <= '0;
            mn_q <= '1;
            mx_q <= '0;
            if (ch_q == ChW'(3)) st_q <= S_PUSH;
            else ch_q <= ch_q + 1'b1;
          end else begin
            sum_q <= sum_q + SumW'(cur);
            if (cur < mn_q) mn_q <= cur;
            if (cur > mx_q) mx_q <= cur;
            k_q <= k_q + 1'b1;
          end
        end
        S_PUSH: begin
          if (q_ready_i) st_q <= S_COLLECT;
        end
        default: st_q <= S_COLLECT;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/ilsp_queue.sv
// Two-entry queue between front and back ends.
// Depends on ilsp_pkg.
`default_nettype none
module ilsp_queue import ilsp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   w_valid_i,
  output logic        w_ready_o,
  input  wire chan_vals_t w_data_i,
  output logic        r_valid_o,
  input  wire logic   r_ready_i,
  output chan_vals_t  r_data_o
);
  chan_vals_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign w_ready_o = (cnt_q != 2'd2);
  assign r_valid_o = (cnt_q != 2'd0);
  assign r_data_o  = mem_q[rp_q];
  assign wr = w_valid_i && w_ready_o;
  assign rd = r_valid_o && r_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= w_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// File: sv/ilsp_div.sv
// Restoring divider: 16-bit quotient of (num << 15) / den, one bit per cycle.
// Depends on ilsp_pkg.
`default_nettype none
module ilsp_div import ilsp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [12:0] num_i,
  input  wire logic [12:0] den_i,
  output logic             done_o,
  output logic [15:0]      quo_o,
  output logic [13:0]      rem_o
);
  logic [4:0] cnt_q;
  logic busy_q;
  logic [27:0] n_q;
  logic [13:0] r_q;
  logic [15:0] qq;
  logic [14:0] trial;

  assign trial = {r_q, n_q[27]} - {2'b00, den_i};
  assign done_o = busy_q && (cnt_q == 5'd0);
  assign quo_o = qq;
  assign rem_o = r_q;

  // Shift and subtract over 28 dividend bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      n_q <= '0;
      r_q <= '0;
      qq <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 5'd28;
      n_q <= {num_i, 15'd0};
      r_q <= '0;
      qq <= '0;
    end else if (busy_q && cnt_q != 5'd0) begin
      cnt_q <= cnt_q - 1'b1;
      n_q <= {n_q[26:0], 1'b0};
      if (!trial[14]) begin
        r_q <= trial[13:0];
        qq <= {qq[14:0], 1'b1};
      end else begin
        r_q <= {r_q[12:0], n_q[27]};
        qq <= {qq[14:0], 1'b0};
      end
    end else begin
      busy_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: sv/ilsp_back.sv
// Back end: stop and mode flags, pair errors, derivatives and the PD drive.
// Depends on ilsp_pkg and ilsp_div.
`default_nettype none
module ilsp_back import ilsp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       q_valid_i,
  output logic            q_ready_o,
  input  wire chan_vals_t q_data_i,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic signed [14:0] drive_o,
  output logic            stop_latched_o,
  output logic            in_roundabout_o
);
  typedef enum logic [2:0] {B_IDLE, B_ERR_H, B_ERR_V, B_MUL1, B_MUL2, B_OUT} st_e;

  st_e st_q;
  samp_t a_q, b_q, c_q, d_q;
  logic start_q;
  logic stop_q, rnd_q;
  logic stop_out_q, rnd_out_q;
  logic signed [16:0] eh_q, ev_q;
  logic signed [16:0] hh_q [DerivLag];
  logic signed [16:0] hv_q [DerivLag];
  logic signed [16:0] dh_q, dv_q;
  logic signed [31:0] pp_q;
  logic signed [14:0] drv_q;
  logic valid_q;

  logic div_done;
  logic [15:0] div_q;
  logic [13:0] div_r;
  samp_t pa, pb;
  logic [12:0] mag, den;
  logic [16:0] qr;
  logic signed [16:0] err_s, dsel, esel;
  logic signed [19:0] dd_raw;
  logic signed [16:0] dd_cl;
  logic signed [31:0] prod;
  logic [31:0] amag;
  logic [17:0] rmag;
  logic signed [18:0] rs;
  logic signed [14:0] rsat;
  logic rnd_n;

  assign pa = (st_q == B_ERR_V) ? c_q : a_q;
  assign pb = (st_q == B_ERR_V) ? d_q : b_q;
  assign mag = (pa >= pb) ? 13'(pa - pb) : 13'(pb - pa);
  assign den = 13'(pa) + 13'(pb);

  ilsp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .num_i  (mag),
    .den_i  (den),
    .done_o (div_done),
    .quo_o  (div_q),
    .rem_o  (div_r)
  );

  // Round to nearest using remainder, sign, clamp to Q1.15.
  always_comb begin
    qr = {1'b0, div_q} + ((15'(div_r) << 1) >= 15'(den) ? 17'd1 : 17'd0);
    err_s = (pa < pb) ? -$signed(qr) : $signed(qr);
    if (err_s > 17'sd32767) err_s = 17'sd32767;
    if (err_s < -17'sd32768) err_s = -17'sd32768;
  end

  // Derivative of the error being finished, clamped.
  always_comb begin
    esel = err_s;
    dsel = (st_q == B_ERR_V) ? hv_q[DerivLag-1] : hh_q[DerivLag-1];
    dd_raw = 20'sd5 * (20'(esel) - 20'(dsel));
    if (dd_raw > 20'sd22938) dd_cl = 17'sd22938;
    else if (dd_raw < -20'sd22938) dd_cl = -17'sd22938;
    else dd_cl = 17'(dd_raw);
  end

  // Mode update on the floored values.
  always_comb begin
    rnd_n = rnd_q;
    if (a_q > cfg_i.enter_high && b_q > cfg_i.enter_high &&
        c_q < cfg_i.enter_low && d_q < cfg_i.enter_low) rnd_n = 1'b1;
    if (rnd_n && c_q > cfg_i.exit_level && d_q > cfg_i.exit_level) rnd_n = 1'b0;
  end

  // One product per cycle, then rounding of the sum.
  always_comb begin
    if (st_q == B_MUL1)
      prod = 32'(rnd_q ? ev_q : eh_q) * $signed({1'b0, 15'(rnd_q ? cfg_i.rp_gain : cfg_i.p_gain)});
    else
      prod = 32'(rnd_q ? dv_q : dh_q) * $signed({1'b0, 15'(rnd_q ? cfg_i.rd_gain : cfg_i.d_gain)});
    amag = pp_q[31] ? 32'(-pp_q) : 32'(pp_q);
    rmag = 18'((amag + 32'd16384) >> 15);
    rs = pp_q[31] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    if (rs > 19'sd16383) rsat = 15'sd16383;
    else if (rs < -19'sd16384) rsat = -15'sd16384;
    else rsat = 15'(rs);
  end

  assign q_ready_o = (st_q == B_IDLE);
  assign out_valid = valid_q;
  assign drive_o = drv_q;
  assign stop_latched_o = stop_out_q;
  assign in_roundabout_o = rnd_out_q;

  // Back-end sequencer and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
      start_q <= 1'b0;
      stop_q <= 1'b0;
      rnd_q <= 1'b0;
      stop_out_q <= 1'b0;
      rnd_out_q <= 1'b0;
      valid_q <= 1'b0;
      for (int i = 0; i < DerivLag; i++) begin
        hh_q[i] <= '0;
        hv_q[i] <= '0;
      end
    end else begin
      start_q <= 1'b0;
      if (out_valid && out_ready && st_q != B_OUT) valid_q <= 1'b0;
      case (st_q)
        B_IDLE: begin
          if (q_valid_i) begin
            if (q_data_i.h_l < cfg_i.stop_thr && q_data_i.h_r < cfg_i.stop_thr)
              stop_q <= 1'b1;
            a_q <= (q_data_i.h_l < 12'd10) ? 12'd10 : q_data_i.h_l;
            b_q <= (q_data_i.h_r < 12'd10) ? 12'd10 : q_data_i.h_r;
            c_q <= (q_data_i.v_l < 12'd10) ? 12'd10 : q_data_i.v_l;
            d_q <= (q_data_i.v_r < 12'd10) ? 12'd10 : q_data_i.v_r;
            start_q <= 1'b1;
            st_q <= B_ERR_H;
          end
        end
        B_ERR_H: begin
          if (div_done) begin
            eh_q <= err_s;
            dh_q <= dd_cl;
            for (int i = DerivLag-1; i > 0; i--) hh_q[i] <= hh_q[i-1];
            hh_q[0] <= err_s;
            start_q <= 1'b1;
            st_q <= B_ERR_V;
          end
        end
        B_ERR_V: begin
          if (div_done) begin
            ev_q <= err_s;
            dv_q <= dd_cl;
            for (int i = DerivLag-1; i > 0; i--) hv_q[i] <= hv_q[i-1];
            hv_q[0] <= err_s;
            rnd_q <= rnd_n;
            st_q <= B_MUL1;
          end
        end
        B_MUL1: begin
          pp_q <= prod;
          st_q <= B_MUL2;
        end
        B_MUL2: begin
          pp_q <= pp_q + prod;
          st_q <= B_OUT;
        end
        B_OUT: begin
          // The flags travel with the drive so a waiting result stays whole.
          if (!valid_q || out_ready) begin
            drv_q <= rsat;
            stop_out_q <= stop_q;
            rnd_out_q <= rnd_q;
            valid_q <= 1'b1;
            st_q <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
